// ===== design/tolerance_vertex_dedup_defines.svh =====
// assertion macros used by the checker file
`ifndef TOLERANCE_VERTEX_DEDUP_DEFINES_SVH
`define TOLERANCE_VERTEX_DEDUP_DEFINES_SVH

// same-cycle implication
`define TVD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tvd_pkg.sv =====
// package: sizes, types and control structs of the vertex dedup block
package tvd_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int COORD_BITS   = 16;
   localparam int MAX_DIM      = 4;
   localparam int LANES        = 4;

   localparam int ROWS     = MAX_VERTICES / LANES;
   localparam int IDX_W    = $clog2(MAX_VERTICES);
   localparam int CNT_W    = IDX_W + 1;
   localparam int LANE_W   = $clog2(LANES);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int ROWCNT_W = CNT_W - LANE_W;
   localparam int WORD_W   = COORD_BITS * MAX_DIM;
   localparam int DIFF_W   = COORD_BITS + 1;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int SUM_W    = SQ_W + $clog2(MAX_DIM) + 1;
   localparam int CMP_W    = 64;
   localparam int TOL_W    = 38;
   localparam int DIM_W    = 3;
   localparam int DATA_W   = 64;
   localparam int ADDR_W   = 4;
   localparam int REG_SEL  = 3;

   localparam logic [TOL_W-1:0] TOL_RESET = '0;
   localparam logic [DIM_W-1:0] DIM_RESET = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } tvd_state_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic finish;
   } tvd_cmd_type;

   typedef struct packed {
      logic rows_done;
      logic pipe_busy;
      logic out_free;
   } tvd_status_type;

endpackage

// ===== design/tvd_ram.sv =====
// generic single-port-write, registered-read ram
module tvd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tvd_ctrl.sv =====
// controller state machine for the vertex search
module tvd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tvd_pkg::tvd_status_type status,
   output tvd_pkg::tvd_cmd_type    cmd
);

   tvd_pkg::tvd_state_type state_ff;
   tvd_pkg::tvd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tvd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tvd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tvd_pkg::ST_SCAN;
            end
         end
         tvd_pkg::ST_SCAN: begin
            if (status.rows_done) begin
               state_in = tvd_pkg::ST_DRAIN;
            end
         end
         tvd_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = tvd_pkg::ST_FINISH;
            end
         end
         tvd_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = tvd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tvd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd.start  = 1'b0;
      cmd.issue  = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         tvd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         tvd_pkg::ST_SCAN: begin
            cmd.issue = !status.rows_done;
         end
         tvd_pkg::ST_DRAIN: begin
            cmd.issue = 1'b0;
         end
         tvd_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== design/tvd_datapath.sv =====
// datapath: banked vertex store, four compare lanes, result register
module tvd_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tvd_pkg::tvd_cmd_type                  cmd,
   output tvd_pkg::tvd_status_type               status,
   input  logic [tvd_pkg::TOL_W-1:0]             tolerance,
   input  logic [tvd_pkg::DIM_W-1:0]             dimension,
   input  logic                                  req_first_of_set,
   input  logic signed [tvd_pkg::COORD_BITS-1:0] req_coord_0,
   input  logic signed [tvd_pkg::COORD_BITS-1:0] req_coord_1,
   input  logic signed [tvd_pkg::COORD_BITS-1:0] req_coord_2,
   input  logic signed [tvd_pkg::COORD_BITS-1:0] req_coord_3,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [tvd_pkg::IDX_W-1:0]             rsp_vertex_number,
   output logic [tvd_pkg::IDX_W-1:0]             rsp_match_number,
   output logic                                  rsp_found,
   output logic                                  rsp_store_full
);

   localparam int CB = tvd_pkg::COORD_BITS;
   localparam int ND = tvd_pkg::MAX_DIM;
   localparam int NL = tvd_pkg::LANES;

   // set bookkeeping
   logic [tvd_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [tvd_pkg::CNT_W-1:0]    n_ff, n_in;
   logic                         full_ff, full_in;
   logic [tvd_pkg::ROWCNT_W-1:0] rows_ff, rows_in;
   logic [tvd_pkg::ROWCNT_W-1:0] row_ff, row_in;
   logic signed [CB-1:0]         coords_ff [ND];
   logic signed [CB-1:0]         coords_in [ND];
   logic [tvd_pkg::CNT_W-1:0]    rows_sum;
   logic [tvd_pkg::WORD_W-1:0]   wr_word;
   logic                         wr_en;

   // compare pipeline
   logic [tvd_pkg::WORD_W-1:0]   rd_data [NL];
   logic                         s0_v_ff, s0_v_in;
   logic [tvd_pkg::ROW_W-1:0]    s0_row_ff, s0_row_in;
   logic                         s1_v_ff, s1_v_in;
   logic [tvd_pkg::ROW_W-1:0]    s1_row_ff, s1_row_in;
   logic [tvd_pkg::SQ_W-1:0]     sq_ff [NL][ND];
   logic [tvd_pkg::SQ_W-1:0]     sq_in [NL][ND];
   logic [NL-1:0]                lane_ok_ff, lane_ok_in;
   logic                         s2_v_ff, s2_v_in;
   logic [tvd_pkg::ROW_W-1:0]    s2_row_ff, s2_row_in;
   logic [NL-1:0]                hit_ff, hit_in;
   logic [tvd_pkg::DIM_W-1:0]    dims_eff;
   logic [ND-1:0]                coord_en;

   // search result and response
   logic                         found_ff, found_in;
   logic [tvd_pkg::IDX_W-1:0]    match_ff, match_in;
   logic [tvd_pkg::LANE_W-1:0]   pick;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tvd_pkg::IDX_W-1:0]    rsp_vertex_ff, rsp_vertex_in;
   logic [tvd_pkg::IDX_W-1:0]    rsp_match_ff, rsp_match_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic                         rsp_full_ff, rsp_full_in;

   // request capture and store write
   always_comb begin
      n_in      = n_ff;
      full_in   = full_ff;
      rows_in   = rows_ff;
      count_in  = count_ff;
      coords_in = coords_ff;
      rows_sum  = '0;
      wr_en     = 1'b0;
      if (cmd.start) begin
         n_in     = req_first_of_set ? '0 : count_ff;
         full_in  = (n_in >= tvd_pkg::CNT_W'(tvd_pkg::MAX_VERTICES));
         rows_sum = n_in + tvd_pkg::CNT_W'(NL - 1);
         rows_in  = rows_sum[tvd_pkg::CNT_W-1:tvd_pkg::LANE_W];
         count_in = full_in ? n_in : n_in + tvd_pkg::CNT_W'(1);
         wr_en    = !full_in;
         coords_in[0] = req_coord_0;
         coords_in[1] = req_coord_1;
         coords_in[2] = req_coord_2;
         coords_in[3] = req_coord_3;
      end
   end

   assign wr_word = {req_coord_3, req_coord_2, req_coord_1, req_coord_0};

   always_comb begin
      row_in = row_ff;
      if (cmd.start) begin
         row_in = '0;
      end else if (cmd.issue) begin
         row_in = row_ff + tvd_pkg::ROWCNT_W'(1);
      end
   end

   genvar b;
   generate
      for (b = 0; b < NL; b++) begin : g_bank
         tvd_ram #(
            .WIDTH (tvd_pkg::WORD_W),
            .DEPTH (tvd_pkg::ROWS)
         ) u_bank (
            .clock   (clock),
            .wr_en   (wr_en && (n_in[tvd_pkg::LANE_W-1:0] == tvd_pkg::LANE_W'(b))),
            .wr_addr (n_in[tvd_pkg::IDX_W-1:tvd_pkg::LANE_W]),
            .wr_data (wr_word),
            .rd_en   (cmd.issue),
            .rd_addr (row_ff[tvd_pkg::ROW_W-1:0]),
            .rd_data (rd_data[b])
         );
      end
   endgenerate

   // dimension clamp
   always_comb begin
      if (dimension == '0) begin
         dims_eff = tvd_pkg::DIM_W'(1);
      end else if (dimension > tvd_pkg::DIM_W'(ND)) begin
         dims_eff = tvd_pkg::DIM_W'(ND);
      end else begin
         dims_eff = dimension;
      end
      for (int d = 0; d < ND; d++) begin
         coord_en[d] = (tvd_pkg::DIM_W'(d) < dims_eff);
      end
   end

   // stage 0 follows the ram read
   assign s0_v_in   = cmd.issue;
   assign s0_row_in = cmd.issue ? row_ff[tvd_pkg::ROW_W-1:0] : s0_row_ff;

   // stage 1: per-coordinate squared differences
   always_comb begin
      logic signed [CB-1:0]              a;
      logic signed [CB-1:0]              c;
      logic signed [tvd_pkg::DIFF_W-1:0] df;
      logic signed [tvd_pkg::SQ_W-1:0]   prod;
      s1_v_in   = s0_v_ff;
      s1_row_in = s0_row_ff;
      for (int l = 0; l < NL; l++) begin
         for (int d = 0; d < ND; d++) begin
            a    = coords_ff[d];
            c    = $signed(rd_data[l][d*CB +: CB]);
            df   = $signed({a[CB-1], a}) - $signed({c[CB-1], c});
            prod = df * df;
            sq_in[l][d] = coord_en[d] ? $unsigned(prod) : '0;
         end
         lane_ok_in[l] = s0_v_ff &&
            (tvd_pkg::CNT_W'({s0_row_ff, tvd_pkg::LANE_W'(l)}) < n_ff);
      end
   end

   // stage 2: sum of squares against tolerance
   always_comb begin
      logic [tvd_pkg::SUM_W-1:0] sum;
      s2_v_in   = s1_v_ff;
      s2_row_in = s1_row_ff;
      for (int l = 0; l < NL; l++) begin
         sum = '0;
         for (int d = 0; d < ND; d++) begin
            sum = sum + tvd_pkg::SUM_W'(sq_ff[l][d]);
         end
         hit_in[l] = lane_ok_ff[l] &&
            (tvd_pkg::CMP_W'(sum) < tvd_pkg::CMP_W'(tolerance));
      end
   end

   // first hit in store order
   always_comb begin
      pick = '0;
      for (int l = NL - 1; l >= 0; l--) begin
         if (hit_ff[l]) begin
            pick = tvd_pkg::LANE_W'(l);
         end
      end
      found_in = found_ff;
      match_in = match_ff;
      if (cmd.start) begin
         found_in = 1'b0;
      end else if (s2_v_ff && !found_ff && (hit_ff != '0)) begin
         found_in = 1'b1;
         match_in = {s2_row_ff, pick};
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_full_in   = rsp_full_ff;
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = full_ff ? '0 : n_ff[tvd_pkg::IDX_W-1:0];
         rsp_match_in  = found_ff ? match_ff : rsp_vertex_in;
         rsp_found_in  = found_ff;
         rsp_full_in   = full_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         row_ff       <= '0;
         rows_ff      <= '0;
         s0_v_ff      <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         row_ff       <= row_in;
         rows_ff      <= rows_in;
         s0_v_ff      <= s0_v_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      full_ff       <= full_in;
      coords_ff     <= coords_in;
      s0_row_ff     <= s0_row_in;
      s1_row_ff     <= s1_row_in;
      sq_ff         <= sq_in;
      lane_ok_ff    <= lane_ok_in;
      s2_row_ff     <= s2_row_in;
      hit_ff        <= hit_in;
      match_ff      <= match_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign status.rows_done = (row_ff == rows_ff);
   assign status.pipe_busy = s0_v_ff || s1_v_ff || s2_v_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_number = rsp_vertex_ff;
   assign rsp_match_number  = rsp_match_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_store_full    = rsp_full_ff;

endmodule

// ===== design/tolerance_vertex_dedup.sv =====
// top level: near-duplicate vertex finder with register port
// Each request is one vertex; first_of_set empties the set before it. The vertex is
// checked against every stored vertex of its set and one response gives its index,
// the index of the first stored vertex whose squared distance is strictly below
// tolerance_squared (else its own index), and flags for a hit and a full store (1024
// vertices; a vertex arriving at a full store is searched but not kept). One request
// is in flight at a time. The store is split into four banks that are read one row
// per cycle into four compare lanes; a waiting response does not block the next
// request. There is no clearing pass after reset. Registers: tolerance_squared at
// byte 0, dimension at 8.
module tolerance_vertex_dedup (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_first_of_set,
   input  logic signed [tvd_pkg::COORD_BITS-1:0] req_coord_0,
   input  logic signed [tvd_pkg::COORD_BITS-1:0] req_coord_1,
   input  logic signed [tvd_pkg::COORD_BITS-1:0] req_coord_2,
   input  logic signed [tvd_pkg::COORD_BITS-1:0] req_coord_3,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tvd_pkg::IDX_W-1:0]             rsp_vertex_number,
   output logic [tvd_pkg::IDX_W-1:0]             rsp_match_number,
   output logic                                  rsp_found,
   output logic                                  rsp_store_full,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tvd_pkg::ADDR_W-1:0]            paddr,
   input  logic [tvd_pkg::DATA_W-1:0]            pwdata,
   output logic [tvd_pkg::DATA_W-1:0]            prdata,
   output logic                                  pready
);

   tvd_pkg::tvd_cmd_type    cmd;
   tvd_pkg::tvd_status_type status;

   logic [tvd_pkg::TOL_W-1:0] tolerance_ff, tolerance_in;
   logic [tvd_pkg::DIM_W-1:0] dimension_ff, dimension_in;
   logic                      wr_strobe;

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite && pready;

   always_comb begin
      tolerance_in = tolerance_ff;
      dimension_in = dimension_ff;
      if (wr_strobe) begin
         if (paddr[tvd_pkg::REG_SEL]) begin
            dimension_in = pwdata[tvd_pkg::DIM_W-1:0];
         end else begin
            tolerance_in = pwdata[tvd_pkg::TOL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= tvd_pkg::TOL_RESET;
         dimension_ff <= tvd_pkg::DIM_RESET;
      end else begin
         tolerance_ff <= tolerance_in;
         dimension_ff <= dimension_in;
      end
   end

   assign prdata = paddr[tvd_pkg::REG_SEL] ? tvd_pkg::DATA_W'(dimension_ff)
                                           : tvd_pkg::DATA_W'(tolerance_ff);

   tvd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tvd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .tolerance         (tolerance_ff),
      .dimension         (dimension_ff),
      .req_first_of_set  (req_first_of_set),
      .req_coord_0       (req_coord_0),
      .req_coord_1       (req_coord_1),
      .req_coord_2       (req_coord_2),
      .req_coord_3       (req_coord_3),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_match_number  (rsp_match_number),
      .rsp_found         (rsp_found),
      .rsp_store_full    (rsp_store_full)
   );

endmodule

// ===== design/tvd_checker.sv =====
// port-level checks for the vertex dedup block, bound to the top level
`include "tolerance_vertex_dedup_defines.svh"

module tvd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [tvd_pkg::IDX_W-1:0] rsp_vertex_number,
   input logic [tvd_pkg::IDX_W-1:0] rsp_match_number,
   input logic                      rsp_found,
   input logic                      rsp_store_full
);

   `TVD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_match_number), "stalled response changed")
   `TVD_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "second request taken while busy")
   `TVD_ASSERT_NOW(a_match_earlier, clock, reset, rsp_valid && rsp_found && !rsp_store_full, rsp_match_number < rsp_vertex_number, "match is not an earlier vertex")
   `TVD_ASSERT_NOW(a_own_index, clock, reset, rsp_valid && !rsp_found && !rsp_store_full, rsp_match_number == rsp_vertex_number, "unmatched vertex lacks own index")
   `TVD_ASSERT_NOW(a_full_zero, clock, reset, rsp_valid && rsp_store_full, (rsp_vertex_number == '0) && (rsp_found || (rsp_match_number == '0)), "full-store response not zeroed")

endmodule

bind tolerance_vertex_dedup tvd_checker u_checker (.*);
